// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared widths, types and helpers for the cotangent weight block.
// Used by tcw_corner_pipe and triangle_cotangent_weights_top.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COORD_W  = 32;
  localparam int EDGE_W   = 33;
  localparam int PROD_W   = 64;
  localparam int MAG_W    = 64;
  localparam int SQ_W     = 128;
  localparam int ROOT_W   = 64;
  localparam int SREM_W   = 66;
  localparam int QUO_W    = 42;
  localparam int FRAC_SH  = 15;
  localparam int H_W      = 42;
  localparam int IDX_W    = 16;
  localparam int WEIGHT_W = 32;
  localparam int SLOT_W   = 4;

  localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd8;
  localparam logic [QUO_W:0]    HALF_COT_CAP = 43'd1 << 40;
  localparam logic signed [H_W:0] W_MAX = 43'sd2147483647;
  localparam logic signed [H_W:0] W_MIN = -43'sd2147483648;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  typedef struct packed {
    vec3_t pi;
    vec3_t pj;
    vec3_t pk;
  } corner_t;

  function automatic logic signed [PROD_W-1:0] smul(input logic signed [EDGE_W-1:0] a,
                                                    input logic signed [EDGE_W-1:0] b);
    logic signed [2*EDGE_W-1:0] p;
    p = a * b;
    return p[PROD_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] sat_w(input logic signed [H_W:0] v);
    logic [WEIGHT_W-1:0] r;
    if (v > W_MAX) r = W_MAX[WEIGHT_W-1:0];
    else if (v < W_MIN) r = W_MIN[WEIGHT_W-1:0];
    else r = v[WEIGHT_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/tcw_corner_pipe.sv =====
// tcw_corner_pipe: per-corner half cotangent pipeline (edges, products,
// squared cross length, pipelined square root and divide). Uses tcw_pkg.
`timescale 1ns / 1ps
module tcw_corner_pipe #(
  parameter int TAG_W = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  tcw_pkg::corner_t              in_corner,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  output logic signed [tcw_pkg::H_W-1:0] out_h,
  output logic                          out_degen,
  output logic [TAG_W-1:0]              out_tag
);
  import tcw_pkg::*;

  // stage 1: edges, halved when any component's magnitude exceeds 2^31
  logic signed [EDGE_W-1:0] e_c [3];
  logic signed [EDGE_W-1:0] f_c [3];
  logic                     wide_c;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] f1_r [3];
  logic                     v1_r;
  logic [TAG_W-1:0]         t1_r;

  always_comb begin
    wide_c = 1'b0;
    for (int t = 0; t < 3; t++) begin
      e_c[t] = $signed({in_corner.pj[t][COORD_W-1], in_corner.pj[t]})
             - $signed({in_corner.pi[t][COORD_W-1], in_corner.pi[t]});
      f_c[t] = $signed({in_corner.pk[t][COORD_W-1], in_corner.pk[t]})
             - $signed({in_corner.pi[t][COORD_W-1], in_corner.pi[t]});
      if (e_c[t] > 33'sd2147483648 || e_c[t] < -33'sd2147483648) wide_c = 1'b1;
      if (f_c[t] > 33'sd2147483648 || f_c[t] < -33'sd2147483648) wide_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        e1_r[t] <= wide_c ? (e_c[t] >>> 1) : e_c[t];
        f1_r[t] <= wide_c ? (f_c[t] >>> 1) : f_c[t];
      end
      t1_r <= in_tag;
    end
  end

  // stage 2: nine products
  logic signed [PROD_W-1:0] ef2_r [3];
  logic signed [PROD_W-1:0] m2_r [6];
  logic                     v2_r;
  logic [TAG_W-1:0]         t2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) ef2_r[t] <= smul(e1_r[t], f1_r[t]);
      m2_r[0] <= smul(e1_r[1], f1_r[2]);
      m2_r[1] <= smul(e1_r[2], f1_r[1]);
      m2_r[2] <= smul(e1_r[2], f1_r[0]);
      m2_r[3] <= smul(e1_r[0], f1_r[2]);
      m2_r[4] <= smul(e1_r[0], f1_r[1]);
      m2_r[5] <= smul(e1_r[1], f1_r[0]);
      t2_r    <= t1_r;
    end
  end

  // stage 3: dot product and cross components
  logic signed [PROD_W+1:0] d3_r;
  logic signed [PROD_W:0]   c3_r [3];
  logic                     v3_r;
  logic [TAG_W-1:0]         t3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_r <= (PROD_W+2)'(ef2_r[0]) + (PROD_W+2)'(ef2_r[1]) + (PROD_W+2)'(ef2_r[2]);
      for (int t = 0; t < 3; t++)
        c3_r[t] <= (PROD_W+1)'(m2_r[2*t]) - (PROD_W+1)'(m2_r[2*t+1]);
      t3_r <= t2_r;
    end
  end

  // stage 4: magnitudes
  logic [MAG_W-1:0]   dmag4_r;
  logic               dneg4_r;
  logic [MAG_W-1:0]   ca4_r [3];
  logic               v4_r;
  logic [TAG_W-1:0]   t4_r;
  logic signed [PROD_W+1:0] dabs_c;
  logic signed [PROD_W:0]   cabs_c [3];

  always_comb begin
    dabs_c = d3_r[PROD_W+1] ? -d3_r : d3_r;
    for (int t = 0; t < 3; t++) cabs_c[t] = c3_r[t][PROD_W] ? -c3_r[t] : c3_r[t];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag4_r <= dabs_c[MAG_W-1:0];
      dneg4_r <= d3_r[PROD_W+1];
      for (int t = 0; t < 3; t++) ca4_r[t] <= cabs_c[t][MAG_W-1:0];
      t4_r <= t3_r;
    end
  end

  // stage 5: 32x32 partial products of each square
  logic [2*32-1:0]  pll5_r [3];
  logic [2*32-1:0]  plh5_r [3];
  logic [2*32-1:0]  phh5_r [3];
  logic [MAG_W-1:0] dmag5_r;
  logic             dneg5_r;
  logic             v5_r;
  logic [TAG_W-1:0] t5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        pll5_r[t] <= ca4_r[t][31:0] * ca4_r[t][31:0];
        plh5_r[t] <= ca4_r[t][63:32] * ca4_r[t][31:0];
        phh5_r[t] <= ca4_r[t][63:32] * ca4_r[t][63:32];
      end
      dmag5_r <= dmag4_r;
      dneg5_r <= dneg4_r;
      t5_r    <= t4_r;
    end
  end

  // stage 6: squares
  logic [SQ_W-1:0]  sq6_r [3];
  logic [MAG_W-1:0] dmag6_r;
  logic             dneg6_r;
  logic             v6_r;
  logic [TAG_W-1:0] t6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++)
        sq6_r[t] <= {phh5_r[t], pll5_r[t]} + (SQ_W'(plh5_r[t]) << 33);
      dmag6_r <= dmag5_r;
      dneg6_r <= dneg5_r;
      t6_r    <= t5_r;
    end
  end

  // stage 7: squared cross length
  logic [SQ_W-1:0]  s7_r;
  logic [MAG_W-1:0] dmag7_r;
  logic             dneg7_r;
  logic             v7_r;
  logic [TAG_W-1:0] t7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_r    <= sq6_r[0] + sq6_r[1] + sq6_r[2];
      dmag7_r <= dmag6_r;
      dneg7_r <= dneg6_r;
      t7_r    <= t6_r;
    end
  end

  // square root, one result bit per stage
  logic [SREM_W-1:0] sq_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_r [ROOT_W+1];
  logic [SQ_W-1:0]   sq_bits_r [ROOT_W+1];
  logic [MAG_W-1:0]  sq_dmag_r [ROOT_W+1];
  logic              sq_dneg_r [ROOT_W+1];
  logic              sq_dg_r   [ROOT_W+1];
  logic [TAG_W-1:0]  sq_tag_r  [ROOT_W+1];
  logic [ROOT_W:0]   sq_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_bits_r[0] <= s7_r;
      sq_dmag_r[0] <= dmag7_r;
      sq_dneg_r[0] <= dneg7_r;
      sq_dg_r[0]   <= (s7_r == '0);
      sq_tag_r[0]  <= t7_r;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    logic [SREM_W+1:0] r2;
    logic [SREM_W+1:0] tr;
    logic [SREM_W+1:0] df;
    assign r2 = {sq_rem_r[k-1], sq_bits_r[k-1][SQ_W-1 -: 2]};
    assign tr = {2'b00, sq_root_r[k-1], 2'b01};
    assign df = r2 - tr;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (r2 >= tr) begin
          sq_rem_r[k]  <= df[SREM_W-1:0];
          sq_root_r[k] <= {sq_root_r[k-1][ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_r[k]  <= r2[SREM_W-1:0];
          sq_root_r[k] <= {sq_root_r[k-1][ROOT_W-2:0], 1'b0};
        end
        sq_bits_r[k] <= {sq_bits_r[k-1][SQ_W-3:0], 2'b00};
        sq_dmag_r[k] <= sq_dmag_r[k-1];
        sq_dneg_r[k] <= sq_dneg_r[k-1];
        sq_dg_r[k]   <= sq_dg_r[k-1];
        sq_tag_r[k]  <= sq_tag_r[k-1];
      end
    end
  end

  // divide |D| * 2^15 by the root, one quotient bit per stage
  localparam int HI_W = MAG_W + FRAC_SH - QUO_W;

  logic [ROOT_W-1:0] dv_n_r    [QUO_W+1];
  logic [ROOT_W-1:0] dv_rem_r  [QUO_W+1];
  logic [QUO_W-1:0]  dv_q_r    [QUO_W+1];
  logic [QUO_W-1:0]  dv_bits_r [QUO_W+1];
  logic              dv_big_r  [QUO_W+1];
  logic              dv_dneg_r [QUO_W+1];
  logic              dv_dg_r   [QUO_W+1];
  logic [TAG_W-1:0]  dv_tag_r  [QUO_W+1];
  logic [QUO_W:0]    dv_v_r;
  logic [ROOT_W-1:0] n_c;
  logic [ROOT_W-1:0] hi_c;

  always_comb begin
    n_c  = sq_dg_r[ROOT_W] ? ROOT_W'(1) : sq_root_r[ROOT_W];
    hi_c = ROOT_W'(sq_dmag_r[ROOT_W][MAG_W-1 -: HI_W]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_n_r[0]    <= n_c;
      dv_rem_r[0]  <= hi_c;
      dv_q_r[0]    <= '0;
      dv_bits_r[0] <= {sq_dmag_r[ROOT_W][MAG_W-HI_W-1:0], {FRAC_SH{1'b0}}};
      dv_big_r[0]  <= (hi_c >= n_c);
      dv_dneg_r[0] <= sq_dneg_r[ROOT_W];
      dv_dg_r[0]   <= sq_dg_r[ROOT_W];
      dv_tag_r[0]  <= sq_tag_r[ROOT_W];
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [ROOT_W:0] r2;
    logic [ROOT_W:0] nn;
    logic [ROOT_W:0] df;
    assign r2 = {dv_rem_r[k-1], dv_bits_r[k-1][QUO_W-1]};
    assign nn = {1'b0, dv_n_r[k-1]};
    assign df = r2 - nn;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (r2 >= nn) begin
          dv_rem_r[k] <= df[ROOT_W-1:0];
          dv_q_r[k]   <= {dv_q_r[k-1][QUO_W-2:0], 1'b1};
        end else begin
          dv_rem_r[k] <= r2[ROOT_W-1:0];
          dv_q_r[k]   <= {dv_q_r[k-1][QUO_W-2:0], 1'b0};
        end
        dv_bits_r[k] <= {dv_bits_r[k-1][QUO_W-2:0], 1'b0};
        dv_n_r[k]    <= dv_n_r[k-1];
        dv_big_r[k]  <= dv_big_r[k-1];
        dv_dneg_r[k] <= dv_dneg_r[k-1];
        dv_dg_r[k]   <= dv_dg_r[k-1];
        dv_tag_r[k]  <= dv_tag_r[k-1];
      end
    end
  end

  // rounding, cap, sign
  logic                  up_c;
  logic [QUO_W:0]        q1_c;
  logic [QUO_W:0]        mag_c;
  logic signed [H_W-1:0] h_c;
  logic signed [H_W-1:0] h_r;
  logic                  dg_r;
  logic                  vo_r;
  logic [TAG_W-1:0]      to_r;

  always_comb begin
    up_c  = {dv_rem_r[QUO_W], 1'b0} >= {1'b0, dv_n_r[QUO_W]};
    q1_c  = {1'b0, dv_q_r[QUO_W]} + (QUO_W+1)'(up_c);
    mag_c = (dv_big_r[QUO_W] || q1_c > HALF_COT_CAP) ? HALF_COT_CAP : q1_c;
    if (dv_dg_r[QUO_W]) h_c = '0;
    else if (dv_dneg_r[QUO_W]) h_c = -$signed(mag_c[H_W-1:0]);
    else h_c = $signed(mag_c[H_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r  <= h_c;
      dg_r <= dv_dg_r[QUO_W];
      to_r <= dv_tag_r[QUO_W];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
      sq_v_r <= '0;
      dv_v_r <= '0;
      vo_r   <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
      sq_v_r <= {sq_v_r[ROOT_W-1:0], v7_r};
      dv_v_r <= {dv_v_r[QUO_W-1:0], sq_v_r[ROOT_W]};
      vo_r   <= dv_v_r[QUO_W];
    end
  end

  assign out_valid = vo_r;
  assign out_h     = h_r;
  assign out_degen = dg_r;
  assign out_tag   = to_r;

endmodule

// ===== rtl/triangle_cotangent_weights_top.sv =====
// triangle_cotangent_weights_top: cotangent Laplacian weights of one triangle.
// Depends on tcw_pkg and tcw_corner_pipe.
//
// Input channel (in_*): one item per triangle, three Q16.16 corners and
// three vertex indices. Output channel (out_*): nine triplets per triangle,
// six off-diagonal entries (two per corner, corners in order) then three
// diagonals; tlast marks the ninth, tuser carries the degenerate flag.
// The three corners of a triangle enter the corner pipeline one after
// another; the pipeline runs 116 stages (7 arithmetic stages, 65 square
// root stages, 43 divide stages, one rounding stage). Throughput is set
// by the single output port, which carries nine triplets per triangle;
// the input takes a new triangle while the previous one still drains.
// A stalled receiver holds the pipeline once a result waits at its end:
// nothing is dropped or repeated. Synchronous reset empties every stage
// and the output.
`timescale 1ns / 1ps
module triangle_cotangent_weights_top #(
  parameter int VERTEX_INDEX_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 each), a_index, b_index,
  // c_index (16 each)
  input  logic [335:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index[15:0], column_index[31:16], weight[63:32]
  output logic [63:0]  out_tdata,
  // degenerate
  output logic [0:0]   out_tuser,
  output logic         out_tlast
);
  import tcw_pkg::*;

  localparam int IDW   = (VERTEX_INDEX_BITS < IDX_W) ? VERTEX_INDEX_BITS : IDX_W;
  localparam int TAG_W = 3 * IDW;

  // input holding register and corner issue
  vec3_t            p_r [3];
  logic [IDW-1:0]   id_r [3];
  logic             fv_r;
  logic [1:0]       fcnt_r;
  logic [1:0]       fcnt_nxt;
  logic             fv_nxt;
  logic             adv;
  logic             in_acc;
  corner_t          corner_c;

  assign in_tready = !fv_r || (adv && fcnt_r == 2'd2);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    fv_nxt   = fv_r;
    fcnt_nxt = fcnt_r;
    if (fv_r && adv) begin
      if (fcnt_r == 2'd2) begin
        fv_nxt   = 1'b0;
        fcnt_nxt = 2'd0;
      end else begin
        fcnt_nxt = fcnt_r + 2'd1;
      end
    end
    if (in_acc) begin
      fv_nxt   = 1'b1;
      fcnt_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= 1'b0;
      fcnt_r <= 2'd0;
    end else begin
      fv_r   <= fv_nxt;
      fcnt_r <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < 3; c++) begin
        for (int t = 0; t < 3; t++) p_r[c][t] <= in_tdata[(3*c+t)*COORD_W +: COORD_W];
        id_r[c] <= in_tdata[9*COORD_W + c*IDX_W +: IDW];
      end
    end
  end

  always_comb begin
    unique case (fcnt_r)
      2'd1:    corner_c = '{pi: p_r[1], pj: p_r[2], pk: p_r[0]};
      2'd2:    corner_c = '{pi: p_r[2], pj: p_r[0], pk: p_r[1]};
      default: corner_c = '{pi: p_r[0], pj: p_r[1], pk: p_r[2]};
    endcase
  end

  // corner pipeline
  logic                  pv;
  logic signed [H_W-1:0] ph;
  logic                  pdg;
  logic [TAG_W-1:0]      ptag;

  tcw_corner_pipe #(.TAG_W(TAG_W)) u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fv_r),
    .in_corner (corner_c),
    .in_tag    ({id_r[2], id_r[1], id_r[0]}),
    .out_valid (pv),
    .out_h     (ph),
    .out_degen (pdg),
    .out_tag   (ptag)
  );

  // collect three corners, then emit nine triplets
  logic signed [H_W-1:0] acc_h_r [3];
  logic                  acc_dg_r [3];
  logic [TAG_W-1:0]      acc_tag_r;
  logic [1:0]            acc_cnt_r;
  logic [1:0]            acc_cnt_nxt;
  logic [1:0]            acc_base;
  logic                  xfer;
  logic                  coll_ready;
  logic                  take;
  logic                  em_done;

  logic [WEIGHT_W-1:0]   em_off_r [3];
  logic [WEIGHT_W-1:0]   em_diag_r [3];
  logic                  em_dg_r [3];
  logic [IDW-1:0]        em_id_r [3];
  logic [SLOT_W-1:0]     em_slot_r;
  logic [SLOT_W-1:0]     em_slot_nxt;
  logic                  em_v_r;
  logic                  em_v_nxt;

  assign em_done    = em_v_r && out_tready && em_slot_r == SLOT_LAST;
  assign xfer       = (acc_cnt_r == 2'd3) && (!em_v_r || em_done);
  assign coll_ready = (acc_cnt_r != 2'd3) || xfer;
  assign take       = pv && coll_ready;
  assign adv        = !pv || coll_ready;

  always_comb begin
    acc_base    = xfer ? 2'd0 : acc_cnt_r;
    acc_cnt_nxt = take ? acc_base + 2'd1 : acc_base;
    em_v_nxt    = em_v_r;
    em_slot_nxt = em_slot_r;
    if (xfer) begin
      em_v_nxt    = 1'b1;
      em_slot_nxt = '0;
    end else if (em_v_r && out_tready) begin
      if (em_slot_r == SLOT_LAST) em_v_nxt = 1'b0;
      else em_slot_nxt = em_slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= 2'd0;
      em_v_r    <= 1'b0;
      em_slot_r <= '0;
    end else begin
      acc_cnt_r <= acc_cnt_nxt;
      em_v_r    <= em_v_nxt;
      em_slot_r <= em_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_h_r[acc_base]  <= ph;
      acc_dg_r[acc_base] <= pdg;
      acc_tag_r          <= ptag;
    end
    if (xfer) begin
      for (int c = 0; c < 3; c++) begin
        em_off_r[c]  <= sat_w(-(H_W+1)'(acc_h_r[c]));
        em_diag_r[c] <= sat_w((H_W+1)'(acc_h_r[(c+1)%3]) + (H_W+1)'(acc_h_r[(c+2)%3]));
        em_dg_r[c]   <= acc_dg_r[c];
        em_id_r[c]   <= acc_tag_r[c*IDW +: IDW];
      end
    end
  end

  // output select
  logic [IDW-1:0]      row_c;
  logic [IDW-1:0]      col_c;
  logic [WEIGHT_W-1:0] w_c;
  logic                dg_c;

  always_comb begin
    unique case (em_slot_r)
      4'd0: begin row_c = em_id_r[1]; col_c = em_id_r[2]; w_c = em_off_r[0]; dg_c = em_dg_r[0]; end
      4'd1: begin row_c = em_id_r[2]; col_c = em_id_r[1]; w_c = em_off_r[0]; dg_c = em_dg_r[0]; end
      4'd2: begin row_c = em_id_r[2]; col_c = em_id_r[0]; w_c = em_off_r[1]; dg_c = em_dg_r[1]; end
      4'd3: begin row_c = em_id_r[0]; col_c = em_id_r[2]; w_c = em_off_r[1]; dg_c = em_dg_r[1]; end
      4'd4: begin row_c = em_id_r[0]; col_c = em_id_r[1]; w_c = em_off_r[2]; dg_c = em_dg_r[2]; end
      4'd5: begin row_c = em_id_r[1]; col_c = em_id_r[0]; w_c = em_off_r[2]; dg_c = em_dg_r[2]; end
      4'd6: begin
        row_c = em_id_r[0]; col_c = em_id_r[0]; w_c = em_diag_r[0];
        dg_c  = em_dg_r[1] | em_dg_r[2];
      end
      4'd7: begin
        row_c = em_id_r[1]; col_c = em_id_r[1]; w_c = em_diag_r[1];
        dg_c  = em_dg_r[2] | em_dg_r[0];
      end
      default: begin
        row_c = em_id_r[2]; col_c = em_id_r[2]; w_c = em_diag_r[2];
        dg_c  = em_dg_r[0] | em_dg_r[1];
      end
    endcase
  end

  assign out_tvalid = em_v_r;
  assign out_tdata  = {w_c, IDX_W'(col_c), IDX_W'(row_c)};
  assign out_tuser  = dg_c;
  assign out_tlast  = (em_slot_r == SLOT_LAST);

endmodule

// ===== rtl/tcw_checker.sv =====
// tcw_checker: port-level checks on the cotangent weight block.
// Bound to triangle_cotangent_weights_top; no package needed.
`timescale 1ns / 1ps
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[15:0] == out_tdata[31:16])
    else $error("last item of a triangle is not a diagonal entry");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !(out_tvalid && out_tlast))
    else $error("two last items back to back");

endmodule

bind triangle_cotangent_weights_top tcw_checker u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/tb_triangle_cotangent_weights_top.sv =====
// Testbench for triangle_cotangent_weights_top: drives triangles, predicts the nine triplets
// of each in exact integer arithmetic and checks every output item in order.
// Depends on tcw_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef struct {
  logic [15:0] row;
  logic [15:0] col;
  logic [31:0] weight;
  logic        degen;
  logic        last;
} triplet_t;

class triplet_scoreboard;
  triplet_t pending[$];
  int       errors;

  function logic [31:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function longint half_cotangent(longint pi[3], longint pj[3], longint pk[3], output bit degen);
    longint             e[3], f[3];
    logic signed [65:0] dot, prod, pa, pb, cr;
    logic [65:0]        mag;
    logic [127:0]       area2, num, quo, rem, cand;
    logic [63:0]        root;
    bit                 wide;
    wide = 0;
    for (int t = 0; t < 3; t++) begin
      e[t] = pj[t] - pi[t];
      f[t] = pk[t] - pi[t];
      if (e[t] > 64'sd2147483648 || e[t] < -64'sd2147483648) wide = 1;
      if (f[t] > 64'sd2147483648 || f[t] < -64'sd2147483648) wide = 1;
    end
    if (wide) begin
      for (int t = 0; t < 3; t++) begin
        e[t] = e[t] >>> 1;
        f[t] = f[t] >>> 1;
      end
    end
    dot = 0;
    area2 = 0;
    for (int t = 0; t < 3; t++) begin
      prod = e[t] * f[t];
      dot = dot + prod;
      pa = e[(t + 1) % 3] * f[(t + 2) % 3];
      pb = e[(t + 2) % 3] * f[(t + 1) % 3];
      cr = pa - pb;
      mag = (cr < 0) ? -cr : cr;
      area2 = area2 + 128'(mag) * 128'(mag);
    end
    if (area2 == 0) begin
      degen = 1;
      return 0;
    end
    degen = 0;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = 128'(root | (64'd1 << b));
      if (cand * cand <= area2) root = cand[63:0];
    end
    mag = (dot < 0) ? -dot : dot;
    num = 128'(mag) << 15;
    quo = num / 128'(root);
    rem = num % 128'(root);
    if (rem >= 128'(root) - rem) quo = quo + 1;
    if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
    return (dot < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function void note_triangle(logic [335:0] d);
    longint      pos[3][3];
    logic [15:0] id[3];
    longint      h[3];
    bit          dg[3];
    triplet_t    tr;
    for (int c = 0; c < 3; c++) begin
      for (int t = 0; t < 3; t++) pos[c][t] = $signed(d[32*(c*3+t) +: 32]);
      id[c] = d[288 + 16*c +: 16];
    end
    for (int c = 0; c < 3; c++) begin
      h[c] = half_cotangent(pos[c], pos[(c+1)%3], pos[(c+2)%3], dg[c]);
      tr.weight = clamp_q16(-h[c]);
      tr.degen = dg[c];
      tr.last = 0;
      tr.row = id[(c+1)%3];
      tr.col = id[(c+2)%3];
      pending.insert(pending.size(), tr);
      tr.row = id[(c+2)%3];
      tr.col = id[(c+1)%3];
      pending.insert(pending.size(), tr);
    end
    for (int c = 0; c < 3; c++) begin
      tr.row = id[c];
      tr.col = id[c];
      tr.weight = clamp_q16(h[(c+1)%3] + h[(c+2)%3]);
      tr.degen = dg[(c+1)%3] || dg[(c+2)%3];
      tr.last = (c == 2);
      pending.insert(pending.size(), tr);
    end
  endfunction

  function void check_triplet(logic [63:0] d, logic degen, logic last);
    triplet_t x;
    if (pending.size() == 0) begin
      $display("%0t unexpected triplet: expected none, actual %h", $time, d);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (d[15:0] !== x.row) begin
      $display("%0t row: expected %h actual %h", $time, x.row, d[15:0]);
      errors++;
    end
    if (d[31:16] !== x.col) begin
      $display("%0t column: expected %h actual %h", $time, x.col, d[31:16]);
      errors++;
    end
    if (d[63:32] !== x.weight) begin
      $display("%0t weight: expected %h actual %h", $time, x.weight, d[63:32]);
      errors++;
    end
    if (degen !== x.degen) begin
      $display("%0t degenerate: expected %b actual %b", $time, x.degen, degen);
      errors++;
    end
    if (last !== x.last) begin
      $display("%0t tlast: expected %b actual %b", $time, x.last, last);
      errors++;
    end
  endfunction
endclass

module tb_triangle_cotangent_weights_top;
  import tcw_pkg::*;

  localparam int RANDOM_ITEMS = 295;
  localparam int QUIET_AFTER  = 250;
  localparam int STALL_LIMIT  = 3000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [335:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;

  triplet_scoreboard sb;
  int  sent;
  int  stall_left;
  int  idle_cycles;
  bit  quiet;

  triangle_cotangent_weights_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [335:0] pack_triangle(int p[9], logic [15:0] a, logic [15:0] b,
                                                 logic [15:0] c);
    logic [335:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = p[i];
    d[303:288] = a;
    d[319:304] = b;
    d[335:320] = c;
    return d;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int small_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [335:0] random_triangle();
    int p[9];
    int d[3];
    int k;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: for (int i = 0; i < 9; i++) p[i] = small_coord(1 << 20);
      8, 9, 10, 11, 12: for (int i = 0; i < 9; i++) p[i] = $urandom;
      13, 14, 15: begin
        k = $urandom_range(0, 6) - 3;
        for (int t = 0; t < 3; t++) begin
          p[t] = small_coord(1 << 20);
          d[t] = small_coord(1000);
          p[3+t] = p[t] + d[t];
          p[6+t] = p[t] + k * d[t];
        end
      end
      16, 17: for (int t = 0; t < 3; t++) begin
        p[t] = small_coord(1 << 24);
        p[3+t] = small_coord(1 << 24);
        p[6+t] = (p[t] >>> 1) + (p[3+t] >>> 1) + small_coord(1);
      end
      default: for (int i = 0; i < 9; i++) p[i] = pick_extreme();
    endcase
    if ($urandom_range(0, 7) == 0)
      return pack_triangle(p, 16'hffff, 16'h0000, 16'($urandom_range(0, 65535)));
    return pack_triangle(p, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
  endfunction

  task automatic send_triangle(logic [335:0] d);
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    if (sent > QUIET_AFTER) quiet = 1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_triangle(in_tdata);
      if (out_tvalid && out_tready) sb.check_triplet(out_tdata, out_tuser[0], out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int p[9];
    sb = new();
    sent = 0;
    quiet = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all corners at the origin
    for (int i = 0; i < 9; i++) p[i] = 0;
    send_triangle(pack_triangle(p, 16'd0, 16'd0, 16'd0));
    // unit right triangle
    p = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
    send_triangle(pack_triangle(p, 16'd0, 16'd1, 16'hffff));
    // equilateral-ish, obtuse, 3d
    p = '{0, 0, 0, 131072, 0, 0, 65536, 113512, 0};
    send_triangle(pack_triangle(p, 16'd10, 16'd20, 16'd30));
    p = '{0, 0, 0, 1 << 20, 0, 0, 1 << 19, 3, 5};
    send_triangle(pack_triangle(p, 16'hffff, 16'hfffe, 16'h8000));
    // collinear corners, two corners coinciding
    p = '{5, 7, 9, 10, 14, 18, 20, 28, 36};
    send_triangle(pack_triangle(p, 16'h1234, 16'h5678, 16'h9abc));
    p = '{-3, 4, 100, -3, 4, 100, 65536, 0, 0};
    send_triangle(pack_triangle(p, 16'h0001, 16'h0002, 16'h0003));
    // thin triangle that saturates the weights
    p = '{32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 1, 0};
    send_triangle(pack_triangle(p, 16'haaaa, 16'h5555, 16'h00ff));
    p = '{0, 0, 0, 1 << 30, 0, 0, 1 << 29, 1, 0};
    send_triangle(pack_triangle(p, 16'h7fff, 16'h8000, 16'hffff));
    // full-range corners, some needing the halved edges
    p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    send_triangle(pack_triangle(p, 16'hffff, 16'hffff, 16'hffff));
    p = '{32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, 32'h80000000,
          32'h7fffffff};
    send_triangle(pack_triangle(p, 16'd0, 16'hffff, 16'd0));
    p = '{-1, -1, -1, 32'h80000000, -1, -1, -1, 32'h7fffffff, -1};
    send_triangle(pack_triangle(p, 16'h0f0f, 16'hf0f0, 16'h3c3c));
    for (int i = 0; i < 9; i++) p[i] = 32'h7fffffff;
    send_triangle(pack_triangle(p, 16'd1, 16'd2, 16'd3));

    for (int n = 0; n < RANDOM_ITEMS; n++) send_triangle(random_triangle());
    in_tvalid <= 1'b0;
    quiet = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
